// File: rtl/core/byte_level_pretokenizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte-level pretokenizer
// Concurrent checks clocked by aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_LEVEL_PRETOKENIZER_UNIT_ASSERT_SVH
`define BYTE_LEVEL_PRETOKENIZER_UNIT_ASSERT_SVH

// Check a condition that must hold at every edge.
`define BLPT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check a consequence in the cycle after the trigger.
`define BLPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Check a consequence in the same cycle as the trigger.
`define BLPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/blpt_pkg.sv
// ----------------------------------------------------------------------------
// blpt_pkg
// Types, codes and byte classifiers shared by the pretokenizer modules.
// ----------------------------------------------------------------------------
package blpt_pkg;

    // Scan modes
    localparam logic [3:0] MODE_BOUNDARY     = 4'd0;
    localparam logic [3:0] MODE_SPACE        = 4'd1;
    localparam logic [3:0] MODE_ALPHA        = 4'd2;
    localparam logic [3:0] MODE_DIGIT        = 4'd3;
    localparam logic [3:0] MODE_PUNCT        = 4'd4;
    localparam logic [3:0] MODE_PUNCT_SP     = 4'd5;
    localparam logic [3:0] MODE_UTF8         = 4'd6;
    localparam logic [3:0] MODE_QUOTE        = 4'd7;
    localparam logic [3:0] MODE_QUOTE_LETTER = 4'd8;

    // Held letter codes
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_L    = 2'd1;
    localparam logic [1:0] HELD_V    = 2'd2;
    localparam logic [1:0] HELD_R    = 2'd3;

    // Byte values
    localparam logic [7:0] QUOTE_BYTE = 8'h27;
    localparam logic [7:0] SPACE_BYTE = 8'h20;
    localparam logic [7:0] ASCII_TOP  = 8'h7F;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_T     = 8'h74;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_D     = 8'h64;
    localparam logic [7:0] CHAR_L     = 8'h6C;
    localparam logic [7:0] CHAR_V     = 8'h76;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_E     = 8'h65;

    // UTF-8 lead byte masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    // Result queue sizing
    localparam int MAX_RES  = 3;
    localparam int OQ_DEPTH = 8;
    localparam int PTR_W    = $clog2(OQ_DEPTH);
    localparam int CNT_W    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       done;
    } res_t;

    typedef struct packed {
        logic [3:0] mode;
        logic [1:0] left;
        logic [1:0] held;
    } scan_state_t;

    typedef struct packed {
        logic [1:0]                cnt;
        res_t [MAX_RES-1:0]        res;
        scan_state_t               next;
    } step_out_t;

    typedef struct packed {
        logic not_empty;
        logic room;
    } oq_status_t;

    typedef struct packed {
        logic       emit;
        logic       start;
        logic [3:0] mode;
        logic [1:0] left;
    } chunk_t;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == SPACE_BYTE || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    // Bytes still owed after a UTF-8 lead byte
    function automatic logic [1:0] lead_extra(input logic [7:0] b);
        if ((b & LEAD2_MASK) == LEAD2_PAT) return 2'd1;
        if ((b & LEAD3_MASK) == LEAD3_PAT) return 2'd2;
        if ((b & LEAD4_MASK) == LEAD4_PAT) return 2'd3;
        return 2'd0;
    endfunction

    function automatic res_t mk_res(input logic [7:0] b, input logic start);
        res_t r;
        r.data  = b;
        r.start = start;
        r.done  = 1'b0;
        return r;
    endfunction

    // Open a new chunk at this byte
    function automatic chunk_t begin_chunk(input logic [7:0] b, input logic eot,
                                           input logic [1:0] left);
        chunk_t c;
        c.emit  = 1'b1;
        c.start = 1'b1;
        c.left  = left;
        c.mode  = MODE_PUNCT;
        if (b == QUOTE_BYTE && !eot) begin
            c.emit = 1'b0;
            c.mode = MODE_QUOTE;
        end else if (b == SPACE_BYTE) begin
            c.mode = MODE_SPACE;
        end else if (is_letter(b)) begin
            c.mode = MODE_ALPHA;
        end else if (is_num(b)) begin
            c.mode = MODE_DIGIT;
        end else if (b > ASCII_TOP) begin
            c.left = lead_extra(b);
            c.mode = (c.left != 2'd0) ? MODE_UTF8 : MODE_BOUNDARY;
        end else if (is_ws(b)) begin
            c.mode = MODE_BOUNDARY;
        end
        return c;
    endfunction

    // Continue the current chunk or open a new one
    function automatic chunk_t feed(input logic [3:0] mode, input logic [1:0] left,
                                    input logic [7:0] b, input logic eot);
        chunk_t f;
        chunk_t cont;
        f          = begin_chunk(b, eot, left);
        cont.emit  = 1'b1;
        cont.start = 1'b0;
        cont.mode  = mode;
        cont.left  = left;
        case (mode)
            MODE_SPACE: begin
                if (is_letter(b)) begin
                    f = cont;
                    f.mode = MODE_ALPHA;
                end else if (is_num(b)) begin
                    f = cont;
                    f.mode = MODE_DIGIT;
                end else if (b > ASCII_TOP) begin
                    f = cont;
                    f.left = lead_extra(b);
                    f.mode = (f.left != 2'd0) ? MODE_UTF8 : MODE_BOUNDARY;
                end else if (!is_ws(b)) begin
                    f = cont;
                    f.mode = MODE_PUNCT_SP;
                end
            end
            MODE_ALPHA: begin
                if (is_letter(b)) f = cont;
            end
            MODE_DIGIT: begin
                if (is_num(b)) f = cont;
            end
            MODE_PUNCT: begin
                if (!is_ws(b) && !is_letter(b) && !is_num(b) && b <= ASCII_TOP) f = cont;
            end
            MODE_PUNCT_SP: begin
                if (!is_ws(b) && !is_letter(b) && !is_num(b)) f = cont;
            end
            MODE_UTF8: begin
                f = cont;
                f.left = left - 2'd1;
                f.mode = (f.left == 2'd0) ? MODE_BOUNDARY : MODE_UTF8;
            end
            default: ;
        endcase
        return f;
    endfunction

endpackage

// File: rtl/core/blpt_step.sv
// ----------------------------------------------------------------------------
// blpt_step
// Per-byte chunking logic: results and next scan state for one text byte.
// ----------------------------------------------------------------------------
module blpt_step import blpt_pkg::*; (
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    input  scan_state_t cur,
    output step_out_t   step_o
);

    res_t [MAX_RES-1:0] res_w;
    logic [1:0]         n_w;
    scan_state_t        nxt;
    logic               handled;
    logic [7:0]         letter;
    logic [7:0]         want;
    chunk_t             fd;

    always_comb begin
        res_w   = '0;
        n_w     = 2'd0;
        nxt     = cur;
        handled = 1'b0;
        fd      = '0;
        letter  = (cur.held == HELD_V) ? CHAR_V : (cur.held == HELD_R) ? CHAR_R : CHAR_L;
        want    = (letter == CHAR_L) ? CHAR_L : CHAR_E;

        if (cur.mode == MODE_QUOTE) begin
            if (text_byte == CHAR_S || text_byte == CHAR_T ||
                text_byte == CHAR_M || text_byte == CHAR_D) begin
                res_w[n_w] = mk_res(QUOTE_BYTE, 1'b1);
                n_w        = n_w + 2'd1;
                res_w[n_w] = mk_res(text_byte, 1'b0);
                n_w        = n_w + 2'd1;
                nxt.mode   = MODE_BOUNDARY;
                handled    = 1'b1;
            end else if (!end_of_text && (text_byte == CHAR_L || text_byte == CHAR_V ||
                                          text_byte == CHAR_R)) begin
                // hold the letter until the next byte settles the contraction
                nxt.held = (text_byte == CHAR_L) ? HELD_L :
                           (text_byte == CHAR_V) ? HELD_V : HELD_R;
                nxt.mode = MODE_QUOTE_LETTER;
                handled  = 1'b1;
            end else begin
                res_w[n_w] = mk_res(QUOTE_BYTE, 1'b1);
                n_w        = n_w + 2'd1;
                nxt.mode   = MODE_PUNCT;
            end
        end else if (cur.mode == MODE_QUOTE_LETTER) begin
            res_w[n_w] = mk_res(QUOTE_BYTE, 1'b1);
            n_w        = n_w + 2'd1;
            nxt.held   = HELD_NONE;
            if (text_byte == want) begin
                res_w[n_w] = mk_res(letter, 1'b0);
                n_w        = n_w + 2'd1;
                res_w[n_w] = mk_res(text_byte, 1'b0);
                n_w        = n_w + 2'd1;
                nxt.mode   = MODE_BOUNDARY;
                handled    = 1'b1;
            end else begin
                res_w[n_w] = mk_res(letter, 1'b1);
                n_w        = n_w + 2'd1;
                nxt.mode   = MODE_ALPHA;
            end
        end

        if (!handled) begin
            fd = feed(nxt.mode, cur.left, text_byte, end_of_text);
            if (fd.emit) begin
                res_w[n_w] = mk_res(text_byte, fd.start);
                n_w        = n_w + 2'd1;
            end
            nxt.mode = fd.mode;
            nxt.left = fd.left;
        end

        // flush at end of text: mark the last result and drop all state
        if (end_of_text) begin
            if (n_w != 2'd0) res_w[n_w - 2'd1].done = 1'b1;
            nxt = '0;
        end
    end

    assign step_o.cnt  = n_w;
    assign step_o.res  = res_w;
    assign step_o.next = nxt;

endmodule

// File: rtl/core/blpt_outq.sv
// ----------------------------------------------------------------------------
// blpt_outq
// Result queue: takes up to three results a cycle, hands out one a cycle.
// ----------------------------------------------------------------------------
module blpt_outq import blpt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         wr_cnt,
    input  res_t [MAX_RES-1:0] wr_data,
    input  logic               rd_en,
    output res_t               rd_data,
    output oq_status_t         status
);

    res_t             mem_reg [OQ_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head_next  = head_reg + PTR_W'(rd_en);
    assign tail_next  = tail_reg + PTR_W'(wr_cnt);
    assign count_next = count_reg + CNT_W'(wr_cnt) - CNT_W'(rd_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (i < int'(wr_cnt)) mem_reg[tail_reg + PTR_W'(i)] <= wr_data[i];
        end
    end

    assign rd_data          = mem_reg[head_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.room      = (count_reg <= CNT_W'(OQ_DEPTH - MAX_RES));

    `include "byte_level_pretokenizer_unit_assert.svh"

    `BLPT_ASSERT_ALWAYS(a_oq_bound, count_reg <= CNT_W'(OQ_DEPTH), "result queue overflow")
    `BLPT_ASSERT_NEXT(a_oq_idle, (wr_cnt == 2'd0) && !rd_en, $stable(count_reg), "queue count moved while idle")
    `BLPT_ASSERT_SAME(a_oq_pop, rd_en, count_reg != '0, "pop from empty result queue")

endmodule

// File: rtl/core/byte_level_pretokenizer_unit.sv
// ----------------------------------------------------------------------------
// byte_level_pretokenizer_unit
// Streaming byte-level pretokenizer: passes each text byte through and marks
// the byte that opens every chunk (contraction, letter/digit/punctuation run,
// UTF-8 character, whitespace).
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                   Handshake
//  s_       in   s_text_byte[7:0], s_end_of_text           s_valid / s_ready
//  m_       out  m_out_byte[7:0], m_chunk_start,           m_valid / m_ready
//                m_text_done
//
//  One request enters per cycle; each byte's results land in the result queue
//  on the edge that accepts it and leave one per cycle from the queue head.
//  A byte gives zero to three results (a held quote and letter, then the
//  byte itself), so input runs at one byte per cycle while output keeps pace.
//  s_ready drops only when the eight-entry result queue holds more than five
//  results; a stalled m_ready fills the queue and then holds off the input.
//  Synchronous active-low reset empties the queue and returns the scan state
//  to a chunk boundary; no clearing pass is needed.
// ----------------------------------------------------------------------------
module byte_level_pretokenizer_unit import blpt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_chunk_start,
    output logic       m_text_done
);

    scan_state_t scan_reg;
    scan_state_t scan_next;
    step_out_t   step;
    oq_status_t  oq_status;
    res_t        head_res;
    logic        in_fire;
    logic [1:0]  push_cnt;

    // Classify the incoming byte against the current scan state
    blpt_step u_step (
        .text_byte   (s_text_byte),
        .end_of_text (s_end_of_text),
        .cur         (scan_reg),
        .step_o      (step)
    );

    assign in_fire   = s_valid && s_ready;
    assign push_cnt  = in_fire ? step.cnt : 2'd0;
    assign scan_next = in_fire ? step.next : scan_reg;

    // Advance the scan state only on an accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
        end else begin
            scan_reg <= scan_next;
        end
    end

    // Queue the results; it also serves as the output register
    blpt_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_cnt  (push_cnt),
        .wr_data (step.res),
        .rd_en   (m_valid && m_ready),
        .rd_data (head_res),
        .status  (oq_status)
    );

    assign s_ready       = oq_status.room;
    assign m_valid       = oq_status.not_empty;
    assign m_out_byte    = head_res.data;
    assign m_chunk_start = head_res.start;
    assign m_text_done   = head_res.done;

    `include "byte_level_pretokenizer_unit_assert.svh"

    // A held letter exists only while its contraction is pending
    `BLPT_ASSERT_SAME(a_held_mode, scan_reg.held != HELD_NONE, scan_reg.mode == MODE_QUOTE_LETTER, "held letter outside quote-letter mode")
    // The end of text always returns the scanner to its reset state
    `BLPT_ASSERT_NEXT(a_eot_clear, in_fire && s_end_of_text, scan_reg == '0, "state not cleared at end of text")
    // UTF-8 continuation bytes are owed only inside a character
    `BLPT_ASSERT_SAME(a_utf8_left, scan_reg.left != 2'd0, scan_reg.mode == MODE_UTF8, "utf8 count outside utf8 mode")

endmodule
